// ----- rtl/dcs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the DMA channel scheduler.
// No dependencies; every other file imports this package.
package dcs_pkg;

    localparam int CHANNELS_DEF        = 4;
    localparam int BYTES_PER_CYCLE_DEF = 8;
    localparam int LEN_W               = 33;   // ceil(2^32 / 1) needs 33 bits

    typedef enum logic [2:0] {
        OP_SUBMIT  = 3'd0,
        OP_QUERY   = 3'd1,
        OP_POLL    = 3'd2,
        OP_WAIT    = 3'd3,
        OP_ADVANCE = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  channel;
        logic [31:0] xfer_bytes;
        logic [63:0] src_address;
        logic [63:0] dst_address;
        logic [31:0] advance_ticks;
    } t_in;

    typedef struct packed {
        logic        granted;
        logic [3:0]  granted_channel;
        logic        done_flag;
        logic [63:0] time_value;
        logic        copy_issue;
        logic [63:0] copy_src;
        logic [63:0] copy_dst;
        logic [31:0] copy_length;
        logic [31:0] submit_total;
        logic [31:0] copy_total;
        logic [63:0] busy_cycles_total;
    } t_out;

    // Broadcast to every channel cell
    typedef struct packed {
        logic             submit;
        logic [63:0]      now;
        logic [LEN_W-1:0] len;
        logic [63:0]      src;
        logic [63:0]      dst;
        logic [31:0]      bytes;
    } t_cell_cmd;

    // What a cell exposes to the selection logic
    typedef struct packed {
        logic        busy;
        logic [63:0] finish;
        logic [63:0] src;
        logic [63:0] dst;
        logic [31:0] length;
    } t_cell_view;

endpackage

// ----- rtl/dcs_len_unit.sv -----
`timescale 1ns / 1ps
// Two-stage transfer length unit: max(1, ceil(bytes / BYTES_PER_CYCLE)).
// Uses dcs_pkg. Reciprocal multiply, then one compare-and-correct step.
module dcs_len_unit #(
    parameter int BYTES_PER_CYCLE = dcs_pkg::BYTES_PER_CYCLE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [31:0]              i_xfer_bytes,
    output logic [dcs_pkg::LEN_W-1:0] o_len
);
    import dcs_pkg::*;

    // floor(2^32 / B); quotient estimate is short by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BYTES_PER_CYCLE);
    localparam logic [38:0] DIV_C = 39'(BYTES_PER_CYCLE);

    logic [31:0]      x;
    logic [64:0]      prod;
    logic [31:0]      r_x;
    logic             r_zero;
    logic [31:0]      r_q_est;
    logic [38:0]      qb;
    logic [38:0]      rem;
    logic [LEN_W-1:0] q;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] r_len;

    // ceil(b/B) = floor((b-1)/B) + 1 for b >= 1; b == 0 gives 1
    assign x    = i_xfer_bytes - 32'd1;
    assign prod = 65'(x) * 65'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= x;
            r_zero  <= (i_xfer_bytes == 32'd0);
            r_q_est <= prod[63:32];
        end
    end

    assign qb  = 39'(r_q_est) * DIV_C;
    assign rem = 39'(r_x) - qb;

    always_comb begin
        q = LEN_W'(r_q_est) + ((rem >= DIV_C) ? LEN_W'(1) : LEN_W'(0));
        if (r_zero) begin
            n_len = LEN_W'(1);
        end else begin
            n_len = q + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= n_len;
        end
    end

    assign o_len = r_len;

endmodule

// ----- rtl/dcs_cell.sv -----
`timescale 1ns / 1ps
// One DMA channel cell: busy flag, finish time and saved transfer.
// Uses dcs_pkg. Cells form a chain; the claim token passes free-channel search down.
module dcs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcs_pkg::t_cell_cmd  i_cmd,
    input  logic                i_release,
    input  logic                i_claim,
    output logic                o_claim,
    output logic                o_grant,
    output logic [63:0]         o_new_finish,
    output dcs_pkg::t_cell_view o_view
);
    import dcs_pkg::*;

    logic        r_busy;
    logic        n_busy;
    logic [63:0] r_finish;
    logic [63:0] n_finish;
    logic [63:0] r_src;
    logic [63:0] r_dst;
    logic [31:0] r_length;
    logic [63:0] start;
    logic        grant;

    assign start        = (i_cmd.now > r_finish) ? i_cmd.now : r_finish;
    assign o_new_finish = start + 64'(i_cmd.len);

    // token still travels while this cell is busy
    assign grant   = i_cmd.submit & i_claim & ~r_busy;
    assign o_claim = i_claim & r_busy;
    assign o_grant = grant;

    always_comb begin
        n_busy   = r_busy;
        n_finish = r_finish;
        if (grant) begin
            n_busy   = 1'b1;
            n_finish = o_new_finish;
        end else if (i_release) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_finish <= 64'd0;
        end else begin
            r_busy   <= n_busy;
            r_finish <= n_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grant) begin
            r_src    <= i_cmd.src;
            r_dst    <= i_cmd.dst;
            r_length <= i_cmd.bytes;
        end
    end

    assign o_view.busy   = r_busy;
    assign o_view.finish = r_finish;
    assign o_view.src    = r_src;
    assign o_view.dst    = r_dst;
    assign o_view.length = r_length;

endmodule

// ----- rtl/dma_channel_scheduler.sv -----
`timescale 1ns / 1ps
// DMA channel scheduler: command in, one result item out per command.
// Uses dcs_pkg, dcs_len_unit and a chain of dcs_cell instances.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes commands:
//   submit, query, poll, wait and advance. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns exactly one result item per command.
//   After the accepting edge, the length unit registers the reciprocal
//   multiply and then the correction; after that the channel cells and the
//   clock update and the result is registered, which raises o_out_valid.
//   Throughput is one item per cycle unless a held result stalls the
//   pipeline; the cell chain updates its state as each command fires, so
//   commands back to back see each other's effects. When the receiver
//   stalls a valid result, the whole pipeline holds and o_in_stall rises
//   in the same cycle; the held result stays on o_out_data.
//   Reset (synchronous, active low) frees all channels, zeroes the clock,
//   finish times and totals, and drops every item in flight.
module dma_channel_scheduler #(
    parameter int CHANNELS        = dcs_pkg::CHANNELS_DEF,
    parameter int BYTES_PER_CYCLE = dcs_pkg::BYTES_PER_CYCLE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dcs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dcs_pkg::t_out o_out_data
);
    import dcs_pkg::*;

    logic             enable;
    logic             r_v1;
    logic             r_v2;
    logic             r_out_valid;
    t_in              r_cmd1;
    t_in              r_cmd2;
    t_out             r_out_data;
    t_out             n_out;
    logic [LEN_W-1:0] len;

    logic [63:0]      r_time;
    logic [63:0]      n_time;
    logic [31:0]      r_submit_cnt;
    logic [31:0]      n_submit_cnt;
    logic [31:0]      r_copy_cnt;
    logic [31:0]      n_copy_cnt;
    logic [63:0]      r_busy_sum;
    logic [63:0]      n_busy_sum;

    logic             fire;
    logic             ch_valid;
    t_cell_view       sel_view;
    t_cell_cmd        cell_cmd;
    t_cell_view       views      [CHANNELS];
    logic [63:0]      new_finish [CHANNELS];
    logic [CHANNELS-1:0] cell_grant;
    logic [CHANNELS-1:0] cell_sel;
    logic [CHANNELS:0]   claim;
    logic             any_grant;
    logic [3:0]       grant_idx;
    logic [63:0]      grant_finish;
    logic [63:0]      wait_time;
    logic             complete;
    logic             issue;

    // whole pipeline advances unless a finished result is held
    assign enable     = !(r_out_valid && i_out_stall);
    assign o_in_stall = !enable;
    assign fire       = r_v2 && enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (enable) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enable) begin
            r_cmd1     <= i_in_data;
            r_cmd2     <= r_cmd1;
            r_out_data <= n_out;
        end
    end

    dcs_len_unit #(
        .BYTES_PER_CYCLE (BYTES_PER_CYCLE)
    ) u_len (
        .i_clk        (i_clk),
        .i_en         (enable),
        .i_xfer_bytes (i_in_data.xfer_bytes),
        .o_len        (len)
    );

    // one extra bit so that CHANNELS = 16 still fits
    assign ch_valid = ({1'b0, r_cmd2.channel} < 5'(CHANNELS));

    always_comb begin
        cell_cmd.submit = fire && (r_cmd2.operation == OP_SUBMIT);
        cell_cmd.now    = r_time;
        cell_cmd.len    = len;
        cell_cmd.src    = r_cmd2.src_address;
        cell_cmd.dst    = r_cmd2.dst_address;
        cell_cmd.bytes  = r_cmd2.xfer_bytes;
    end

    assign claim[0] = 1'b1;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        assign cell_sel[g] = (r_cmd2.channel == 4'(g));

        dcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cell_cmd),
            .i_release    (complete && cell_sel[g]),
            .i_claim      (claim[g]),
            .o_claim      (claim[g+1]),
            .o_grant      (cell_grant[g]),
            .o_new_finish (new_finish[g]),
            .o_view       (views[g])
        );
    end

    always_comb begin
        sel_view     = '0;
        grant_idx    = 4'd0;
        grant_finish = 64'd0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (cell_sel[i]) begin
                sel_view = views[i];
            end
            if (cell_grant[i]) begin
                grant_idx    = 4'(i);
                grant_finish = new_finish[i];
            end
        end
    end

    assign any_grant = |cell_grant;
    assign wait_time = (sel_view.finish > r_time) ? sel_view.finish : r_time;

    // wait always lands at or past the finish time, so a busy channel completes
    assign complete = fire && ch_valid && sel_view.busy &&
                      (((r_cmd2.operation == OP_POLL) && (r_time >= sel_view.finish)) ||
                       (r_cmd2.operation == OP_WAIT));
    assign issue    = complete && (sel_view.src != 64'd0) && (sel_view.dst != 64'd0);

    always_comb begin
        n_time       = r_time;
        n_submit_cnt = r_submit_cnt + (any_grant ? 32'd1 : 32'd0);
        n_copy_cnt   = r_copy_cnt + (complete ? 32'd1 : 32'd0);
        n_busy_sum   = r_busy_sum + (any_grant ? 64'(len) : 64'd0);
        n_out        = '0;

        unique case (r_cmd2.operation)
            OP_SUBMIT: begin
                n_out.granted         = any_grant;
                n_out.granted_channel = grant_idx;
                n_out.time_value      = grant_finish;
            end
            OP_QUERY: begin
                n_out.done_flag  = ch_valid ? (r_time >= sel_view.finish) : 1'b1;
                n_out.time_value = ch_valid ? sel_view.finish : r_time;
            end
            OP_POLL: begin
                n_out.done_flag  = ch_valid ?
                                   (!sel_view.busy || (r_time >= sel_view.finish)) : 1'b1;
                n_out.time_value = r_time;
            end
            OP_WAIT: begin
                if (ch_valid) begin
                    n_time = wait_time;
                end
                n_out.done_flag  = 1'b1;
                n_out.time_value = ch_valid ? wait_time : r_time;
            end
            OP_ADVANCE: begin
                n_time           = r_time + 64'(r_cmd2.advance_ticks);
                n_out.time_value = n_time;
            end
            default: begin
            end
        endcase

        if (issue) begin
            n_out.copy_issue  = 1'b1;
            n_out.copy_src    = sel_view.src;
            n_out.copy_dst    = sel_view.dst;
            n_out.copy_length = sel_view.length;
        end

        n_out.submit_total      = n_submit_cnt;
        n_out.copy_total        = n_copy_cnt;
        n_out.busy_cycles_total = n_busy_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= 64'd0;
            r_submit_cnt <= 32'd0;
            r_copy_cnt   <= 32'd0;
            r_busy_sum   <= 64'd0;
        end else if (fire) begin
            r_time       <= n_time;
            r_submit_cnt <= n_submit_cnt;
            r_copy_cnt   <= n_copy_cnt;
            r_busy_sum   <= n_busy_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // at most one cell takes a submit
    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_grant))
        else $error("more than one channel granted");

    // a copy is only issued by a finished poll or wait
    a_issue_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.copy_issue || o_out_data.done_flag))
        else $error("copy issued without done");

    // an item leaving the length unit shows up as a result next cycle
    a_pipe_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("result lost in pipeline");

endmodule
